// ----- hdl/prsd_pkg.sv -----
// Shared types and constants for the printable RLE stream decoder.
// No dependencies; every other file of the block imports this package.
package prsd_pkg;

    localparam int DATA_W   = 8;
    localparam int CHAR_W   = 7;
    localparam int CNT_W    = 6;
    localparam int NPFX     = 4;
    localparam int PCNT_W   = 3;
    localparam int ADDR_W   = 5;
    localparam int APB_W    = 32;
    localparam int RIDX_W   = 3;

    localparam logic [CHAR_W-1:0] PRINT_LO = 7'h20;
    localparam logic [CHAR_W-1:0] PRINT_HI = 7'h7E;

    // Register indexes, byte address is 4 * index
    localparam logic [RIDX_W-1:0] REG_REPEAT_MARKER = 3'd0;
    localparam logic [RIDX_W-1:0] REG_PREFIX_CHAR_0 = 3'd1;
    localparam logic [RIDX_W-1:0] REG_PREFIX_CHAR_1 = 3'd2;
    localparam logic [RIDX_W-1:0] REG_PREFIX_CHAR_2 = 3'd3;
    localparam logic [RIDX_W-1:0] REG_PREFIX_CHAR_3 = 3'd4;
    localparam logic [RIDX_W-1:0] REG_PREFIX_COUNT  = 3'd5;

    localparam logic [CHAR_W-1:0] RST_REPEAT_MARKER = 7'd126;
    localparam logic [CHAR_W-1:0] RST_PREFIX_CHAR_0 = 7'd32;
    localparam logic [CHAR_W-1:0] RST_PREFIX_CHAR_1 = 7'd33;
    localparam logic [CHAR_W-1:0] RST_PREFIX_CHAR_2 = 7'd34;
    localparam logic [CHAR_W-1:0] RST_PREFIX_CHAR_3 = 7'd35;
    localparam logic [PCNT_W-1:0] RST_PREFIX_COUNT  = 3'd4;

    typedef struct packed {
        logic [CHAR_W-1:0]            repeat_marker;
        logic [NPFX-1:0][CHAR_W-1:0]  prefix_char;
        logic [PCNT_W-1:0]            prefix_count;
    } t_cfg;

    // Controller to datapath
    typedef struct packed {
        logic load;   // input item accepted: decode it
        logic step;   // result item taken: count down the run
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic emit;   // the offered input item starts a run
        logic last;   // the current copy closes the run
    } t_status;

endpackage

// ----- hdl/prsd_in_if.sv -----
// Input channel of the decoder: one raw line byte per item.
// Depends on prsd_pkg.
interface prsd_in_if;
    import prsd_pkg::*;

    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] line_byte;

    modport source (output valid, output line_byte, input ready);
    modport sink   (input valid, input line_byte, output ready);
endinterface

// ----- hdl/prsd_out_if.sv -----
// Output channel of the decoder: one decoded byte and run flag per item.
// Depends on prsd_pkg.
interface prsd_out_if;
    import prsd_pkg::*;

    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] data_byte;
    logic              run_last;

    modport source (output valid, output data_byte, output run_last, input ready);
    modport sink   (input valid, input data_byte, input run_last, output ready);
endinterface

// ----- hdl/printable_rle_stream_decoder_unit.sv -----
// Top level of the printable RLE stream decoder.
// Depends on prsd_pkg, prsd_in_if, prsd_out_if, prsd_regs, prsd_ctrl, prsd_dp.
//
// Usage:
//   i_line  - input item channel (valid/ready), one raw line byte per item.
//             Bit 7 is ignored; bytes outside 0x20..0x7E are swallowed.
//   o_data  - result item channel (valid/ready): decoded byte plus run_last,
//             which is high on the final copy of a run.
//   APB     - six registers at byte addresses 0,4,..,20: repeat marker,
//             prefix characters 0..3, prefix count. pready is always high.
//             Write only while the block is idle.
// Timing:
//   A byte that decodes to data is taken while the block is idle and its
//   first copy shows on o_data the next cycle. A run of N copies (N = 1..63)
//   is paced by the run counter in the datapath, and no new byte is taken
//   until the last copy is gone. Marker, prefix, count and dropped bytes
//   produce no output and leave the input open.
// Reset (synchronous, active low): decoder back to normal mode with no
//   pending prefix or count, registers to their defaults, output empty.
// Stall: while o_data.ready is low the current copy holds steady and the
//   input stays blocked.
module printable_rle_stream_decoder_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    prsd_in_if.sink                     i_line,
    prsd_out_if.source                  o_data,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [prsd_pkg::ADDR_W-1:0] paddr,
    input  logic [prsd_pkg::APB_W-1:0]  pwdata,
    output logic [prsd_pkg::APB_W-1:0]  prdata,
    output logic                        pready
);
    import prsd_pkg::*;

    t_cfg    w_cfg;
    t_cmd    w_cmd;
    t_status w_status;

    // Register file
    prsd_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Handshake sequencing: idle takes bytes, emit drains the run
    prsd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_line.valid),
        .o_in_ready  (i_line.ready),
        .o_out_valid (o_data.valid),
        .i_out_ready (o_data.ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    // Decode state, held byte and copy counter
    prsd_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_cmd       (w_cmd),
        .i_line_byte (i_line.line_byte),
        .o_status    (w_status),
        .o_data_byte (o_data.data_byte),
        .o_run_last  (o_data.run_last)
    );
endmodule

// ----- hdl/prsd_regs.sv -----
// APB-style configuration registers of the decoder.
// Depends on prsd_pkg.
module prsd_regs (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [prsd_pkg::ADDR_W-1:0] paddr,
    input  logic [prsd_pkg::APB_W-1:0]  pwdata,
    output logic [prsd_pkg::APB_W-1:0]  prdata,
    output logic                       pready,
    output prsd_pkg::t_cfg             o_cfg
);
    import prsd_pkg::*;

    t_cfg              r_cfg;
    logic [RIDX_W-1:0] w_idx;
    logic              w_wr;

    assign w_idx  = paddr[ADDR_W-1:2];
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.repeat_marker  <= RST_REPEAT_MARKER;
            r_cfg.prefix_char[0] <= RST_PREFIX_CHAR_0;
            r_cfg.prefix_char[1] <= RST_PREFIX_CHAR_1;
            r_cfg.prefix_char[2] <= RST_PREFIX_CHAR_2;
            r_cfg.prefix_char[3] <= RST_PREFIX_CHAR_3;
            r_cfg.prefix_count   <= RST_PREFIX_COUNT;
        end else if (w_wr) begin
            case (w_idx)
                REG_REPEAT_MARKER: r_cfg.repeat_marker  <= pwdata[CHAR_W-1:0];
                REG_PREFIX_CHAR_0: r_cfg.prefix_char[0] <= pwdata[CHAR_W-1:0];
                REG_PREFIX_CHAR_1: r_cfg.prefix_char[1] <= pwdata[CHAR_W-1:0];
                REG_PREFIX_CHAR_2: r_cfg.prefix_char[2] <= pwdata[CHAR_W-1:0];
                REG_PREFIX_CHAR_3: r_cfg.prefix_char[3] <= pwdata[CHAR_W-1:0];
                REG_PREFIX_COUNT:  r_cfg.prefix_count   <= pwdata[PCNT_W-1:0];
                default: ;  // drop writes beyond the register list
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (w_idx)
            REG_REPEAT_MARKER: prdata = APB_W'(r_cfg.repeat_marker);
            REG_PREFIX_CHAR_0: prdata = APB_W'(r_cfg.prefix_char[0]);
            REG_PREFIX_CHAR_1: prdata = APB_W'(r_cfg.prefix_char[1]);
            REG_PREFIX_CHAR_2: prdata = APB_W'(r_cfg.prefix_char[2]);
            REG_PREFIX_CHAR_3: prdata = APB_W'(r_cfg.prefix_char[3]);
            REG_PREFIX_COUNT:  prdata = APB_W'(r_cfg.prefix_count);
            default:           prdata = '0;
        endcase
    end
endmodule

// ----- hdl/prsd_dp.sv -----
// Datapath of the decoder: byte classification, decode state, run counter.
// Depends on prsd_pkg.
module prsd_dp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  prsd_pkg::t_cfg              i_cfg,
    input  prsd_pkg::t_cmd              i_cmd,
    input  logic [prsd_pkg::DATA_W-1:0] i_line_byte,
    output prsd_pkg::t_status           o_status,
    output logic [prsd_pkg::DATA_W-1:0] o_data_byte,
    output logic                        o_run_last
);
    import prsd_pkg::*;

    localparam logic [1:0] MODE_NORMAL = 2'd0;
    localparam logic [1:0] MODE_PREFIX = 2'd1;
    localparam logic [1:0] MODE_COUNT  = 2'd2;

    logic [1:0]        r_mode, n_mode;
    logic [1:0]        r_top, n_top;
    logic [CNT_W-1:0]  r_rcnt, n_rcnt;
    logic [CNT_W-1:0]  r_left, n_left;
    logic [DATA_W-1:0] r_data, n_data;

    logic [CHAR_W-1:0] w_c;
    logic              w_print;
    logic [PCNT_W-1:0] w_lim;
    logic              w_hit;
    logic [1:0]        w_idx;
    logic              w_emit;
    logic [DATA_W-1:0] w_data;

    assign w_c     = i_line_byte[CHAR_W-1:0];
    assign w_print = (w_c >= PRINT_LO) && (w_c <= PRINT_HI);
    assign w_lim   = (i_cfg.prefix_count > PCNT_W'(NPFX)) ? PCNT_W'(NPFX)
                                                          : i_cfg.prefix_count;

    // Lowest matching prefix index wins: scan from the top down
    always_comb begin
        w_hit = 1'b0;
        w_idx = '0;
        for (int k = NPFX - 1; k >= 0; k--) begin
            if ((PCNT_W'(k) < w_lim) && (w_c == i_cfg.prefix_char[k])) begin
                w_hit = 1'b1;
                w_idx = 2'(k);
            end
        end
    end

    // Classify the offered byte against the current mode
    always_comb begin
        n_mode = r_mode;
        n_top  = r_top;
        n_rcnt = r_rcnt;
        w_emit = 1'b0;
        w_data = {1'b0, w_c};
        if (w_print) begin
            n_mode = MODE_NORMAL;
            case (r_mode)
                MODE_PREFIX: begin
                    w_data = {r_top, w_c[CNT_W-1:0]};
                    w_emit = 1'b1;
                end
                MODE_COUNT: begin
                    n_rcnt = w_c[CNT_W-1:0];
                end
                default: begin
                    if (w_c == i_cfg.repeat_marker) begin
                        n_mode = MODE_COUNT;
                    end else if (w_hit) begin
                        n_top  = w_idx;
                        n_mode = MODE_PREFIX;
                    end else begin
                        w_emit = 1'b1;
                    end
                end
            endcase
            if (w_emit) begin
                n_rcnt = '0;
            end
        end
    end

    // Run length and decoded byte for the output stage
    always_comb begin
        n_left = r_left;
        n_data = r_data;
        if (i_cmd.load && w_emit) begin
            n_data = w_data;
            n_left = (r_rcnt == '0) ? CNT_W'(1) : r_rcnt;
        end else if (i_cmd.step) begin
            n_left = r_left - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_NORMAL;
            r_top  <= '0;
            r_rcnt <= '0;
        end else if (i_cmd.load) begin
            r_mode <= n_mode;
            r_top  <= n_top;
            r_rcnt <= n_rcnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_left <= n_left;
        r_data <= n_data;
    end

    assign o_status.emit = w_emit;
    assign o_status.last = (r_left == CNT_W'(1));
    assign o_data_byte   = r_data;
    assign o_run_last    = o_status.last;
endmodule

// ----- hdl/prsd_ctrl.sv -----
// Controller of the decoder: takes bytes while idle, emits a run's copies.
// Depends on prsd_pkg.
module prsd_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    input  prsd_pkg::t_status    i_status,
    output prsd_pkg::t_cmd       o_cmd
);
    import prsd_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EMIT = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   w_in_acc;
    logic   w_out_acc;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_EMIT);
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_out_acc   = o_out_valid && i_out_ready;
    assign o_cmd.load  = w_in_acc;
    assign o_cmd.step  = w_out_acc;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc && i_status.emit) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_out_acc && i_status.last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule

// ----- hdl/prsd_chk.sv -----
// Port-level checker for the printable RLE stream decoder, with its bind.
// Depends on printable_rle_stream_decoder_unit and prsd_pkg.
module prsd_chk (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_ready,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic [prsd_pkg::DATA_W-1:0] i_out_data,
    input logic                        i_out_last
);
    import prsd_pkg::*;

    // Reset leaves an empty output and an open input
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid && i_in_ready)
        else $error("output not empty after reset");

    // Hold a stalled copy steady
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_data) && $stable(i_out_last))
        else $error("stalled item changed");

    // Never take a byte while a run is on the output
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in_ready && i_out_valid))
        else $error("input open during a run");

    // A run continues until its flagged copy, with the same byte
    a_run_cont: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && !i_out_last |=>
            i_out_valid && $stable(i_out_data))
        else $error("run broken before its last copy");

    // The flagged copy reopens the input
    a_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && i_out_last |=> i_in_ready && !i_out_valid)
        else $error("input not reopened after run");
endmodule

bind printable_rle_stream_decoder_unit prsd_chk u_prsd_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_line.ready),
    .i_out_valid (o_data.valid),
    .i_out_ready (o_data.ready),
    .i_out_data  (o_data.data_byte),
    .i_out_last  (o_data.run_last)
);
